// ===== hdl/ckup_pkg.sv =====
`timescale 1ns / 1ps
package ckup_pkg;

   localparam int DATA_W = 32;
   localparam int STEP_W = 31;
   localparam int WIDE_W = 66;
   localparam logic [STEP_W-1:0] STEP_RESET = 31'd655;

   typedef logic signed [DATA_W-1:0] word_type;
   typedef logic signed [WIDE_W-1:0] wide_type;

   typedef struct packed {
      word_type val;
      logic     ovf;
   } sat_type;

   localparam wide_type S32_MAX = 66'sd2147483647;
   localparam wide_type S32_MIN = -66'sd2147483648;

   function automatic wide_type wide(input word_type v);
      return WIDE_W'(v);
   endfunction

   function automatic sat_type sat32(input wide_type v);
      sat_type r;
      if (v > S32_MAX) begin
         r.val = word_type'(S32_MAX[DATA_W-1:0]);
         r.ovf = 1'b1;
      end else if (v < S32_MIN) begin
         r.val = word_type'(S32_MIN[DATA_W-1:0]);
         r.ovf = 1'b1;
      end else begin
         r.val = v[DATA_W-1:0];
         r.ovf = 1'b0;
      end
      return r;
   endfunction

   // Exact product, then round to nearest with ties toward plus infinity.
   function automatic wide_type rmul(input logic signed [DATA_W:0] a,
                                     input logic signed [DATA_W:0] b,
                                     input int frac);
      wide_type p;
      p = WIDE_W'(a) * WIDE_W'(b);
      p = p + (wide_type'(1) <<< (frac - 1));
      return p >>> frac;
   endfunction

   function automatic logic signed [DATA_W:0] ext(input word_type v);
      return {v[DATA_W-1], v};
   endfunction

endpackage

// ===== hdl/ckup_req_if.sv =====
`timescale 1ns / 1ps
interface ckup_req_if;
   logic        valid;
   logic        ready;
   logic signed [31:0] pole_re;
   logic signed [31:0] pole_im;
   logic signed [31:0] mem_prev_re;
   logic signed [31:0] mem_prev_im;
   logic signed [31:0] grad_prev;
   logic signed [31:0] grad_now;

   modport source (output valid, pole_re, pole_im, mem_prev_re, mem_prev_im,
                   grad_prev, grad_now, input ready);
   modport sink (input valid, pole_re, pole_im, mem_prev_re, mem_prev_im,
                 grad_prev, grad_now, output ready);
endinterface

// ===== hdl/ckup_rsp_if.sv =====
`timescale 1ns / 1ps
interface ckup_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [31:0] mem_re;
   logic signed [31:0] mem_im;
   logic        range_flag;

   modport source (output valid, mem_re, mem_im, range_flag, input ready);
   modport sink (input valid, mem_re, mem_im, range_flag, output ready);
endinterface

// ===== hdl/complex_memory_kernel_update_core.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake      Contents
// req_chan  in         valid/ready    pole, previous memory, two gradient samples
// rsp_chan  out        valid/ready    updated memory, range flag
// csr       in         write enable   time step, unsigned fixed point
//
// Seven register stages. Throughput is one transaction per cycle while the
// output is ready. Reset clears the stage valid bits, holds the input off
// and loads the time step with 655.
// A stalled output freezes every stage, so nothing is lost or repeated.
module complex_memory_kernel_update_core #(
   parameter int SERIES_ORDER = 3,
   parameter int FRAC_BITS    = 16
) (
   input  logic clock,
   input  logic reset,
   ckup_req_if.sink   req_chan,
   ckup_rsp_if.source rsp_chan,
   input  logic                          csr_we,
   input  logic [ckup_pkg::STEP_W-1:0]   csr_wdata
);
   import ckup_pkg::*;

   localparam wide_type Q_ONE  = wide_type'(1) <<< FRAC_BITS;
   localparam wide_type Q_HALF = wide_type'(1) <<< (FRAC_BITS - 1);
   localparam wide_type Q_NINTH = (2 * Q_ONE + 9) / 18;
   localparam wide_type C2 = (SERIES_ORDER >= 2) ? Q_HALF : wide_type'(0);
   localparam wide_type C3 = (SERIES_ORDER >= 3) ? Q_NINTH : wide_type'(0);
   localparam logic signed [DATA_W:0] C3_OP = C3[DATA_W:0];

   logic [STEP_W-1:0] step_ff;
   logic signed [DATA_W:0] dt;
   logic en;

   logic [7:1] v_ff;

   word_type mr_ff [1:5];
   word_type mi_ff [1:5];
   word_type gp_ff [1:5];
   word_type gn_ff [1:5];
   logic     fl_ff [1:7];

   word_type x1re_ff, x1im_ff, x2re_ff, x2im_ff, x3re_ff, x3im_ff, x4re_ff, x4im_ff;
   word_type sre_ff, sim_ff, tre_ff;
   word_type ure_ff, uim_ff, tcre_ff, tcim_ff, bre_ff, bim_ff;
   word_type b4re_ff, b4im_ff, vre_ff, vim_ff, tfre_ff, tfim_ff;
   word_type epre_ff, epim_ff, are_ff, aim_ff, b5re_ff, b5im_ff;
   wide_type p_ff [0:7];
   word_type ore_ff, oim_ff;

   sat_type x1re_in, x1im_in;
   sat_type s2a, sre_in, sim_in, tre_in;
   word_type ure_in, uim_in, tcre_in, tcim_in;
   logic u_ovf, tc_ovf, v_ovf;
   sat_type bre_in, bim_in;
   word_type vre_in, vim_in;
   sat_type tfre_in;
   sat_type dre, dim, epre_in, are_in, aim_in;
   sat_type ore_in, oim_in;

   assign dt = {2'b00, step_ff};
   assign en = ~v_ff[7] | rsp_chan.ready;
   assign req_chan.ready = en & ~reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_RESET;
      end else if (csr_we) begin
         step_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[6:1], req_chan.valid};
      end
   end

   always_comb begin
      x1re_in = sat32(rmul(ext(req_chan.pole_im), dt, FRAC_BITS));
      x1im_in = sat32(rmul(-ext(req_chan.pole_re), dt, FRAC_BITS));
      s2a     = sat32(rmul(C3_OP, ext(x1re_ff), FRAC_BITS));
      sre_in  = sat32(wide(s2a.val) + C2);
      sim_in  = sat32(rmul(C3_OP, ext(x1im_ff), FRAC_BITS));
      tre_in  = sat32(wide(sre_in.val) - C3);
      bre_in  = sat32(rmul(dt, ext(sre_ff), FRAC_BITS));
      bim_in  = sat32(rmul(dt, ext(sim_ff), FRAC_BITS));
      tfre_in = sat32(wide(tcre_ff) + Q_ONE - C2);
      dre     = sat32(wide(x4re_ff) + wide(vre_ff));
      dim     = sat32(wide(x4im_ff) + wide(vim_ff));
      epre_in = sat32(wide(dre.val) + Q_ONE);
      are_in  = sat32(rmul(dt, ext(tfre_ff), FRAC_BITS));
      aim_in  = sat32(rmul(dt, ext(tfim_ff), FRAC_BITS));
      ore_in  = sat32(p_ff[0] - p_ff[1] + p_ff[2] + p_ff[3]);
      oim_in  = sat32(p_ff[4] + p_ff[5] + p_ff[6] + p_ff[7]);
   end

   ckup_cmul #(.FRAC_BITS(FRAC_BITS)) u_mul_u (
      .a_re(x2re_ff), .a_im(x2im_ff), .b_re(sre_ff), .b_im(sim_ff),
      .r_re(ure_in), .r_im(uim_in), .ovf(u_ovf));

   ckup_cmul #(.FRAC_BITS(FRAC_BITS)) u_mul_t (
      .a_re(x2re_ff), .a_im(x2im_ff), .b_re(tre_ff), .b_im(sim_ff),
      .r_re(tcre_in), .r_im(tcim_in), .ovf(tc_ovf));

   ckup_cmul #(.FRAC_BITS(FRAC_BITS)) u_mul_v (
      .a_re(x3re_ff), .a_im(x3im_ff), .b_re(ure_ff), .b_im(uim_ff),
      .r_re(vre_in), .r_im(vim_in), .ovf(v_ovf));

   always_ff @(posedge clock) begin
      if (en) begin
         mr_ff[1] <= req_chan.mem_prev_re;
         mi_ff[1] <= req_chan.mem_prev_im;
         gp_ff[1] <= req_chan.grad_prev;
         gn_ff[1] <= req_chan.grad_now;
         for (int i = 2; i <= 5; i++) begin
            mr_ff[i] <= mr_ff[i-1];
            mi_ff[i] <= mi_ff[i-1];
            gp_ff[i] <= gp_ff[i-1];
            gn_ff[i] <= gn_ff[i-1];
         end

         x1re_ff  <= x1re_in.val;
         x1im_ff  <= x1im_in.val;
         fl_ff[1] <= (req_chan.pole_re == '0 && req_chan.pole_im == '0)
                     | x1re_in.ovf | x1im_in.ovf;

         x2re_ff  <= x1re_ff;
         x2im_ff  <= x1im_ff;
         sre_ff   <= sre_in.val;
         sim_ff   <= sim_in.val;
         tre_ff   <= tre_in.val;
         fl_ff[2] <= fl_ff[1] | s2a.ovf | sre_in.ovf | sim_in.ovf | tre_in.ovf;

         x3re_ff  <= x2re_ff;
         x3im_ff  <= x2im_ff;
         ure_ff   <= ure_in;
         uim_ff   <= uim_in;
         tcre_ff  <= tcre_in;
         tcim_ff  <= tcim_in;
         bre_ff   <= bre_in.val;
         bim_ff   <= bim_in.val;
         fl_ff[3] <= fl_ff[2] | u_ovf | tc_ovf | bre_in.ovf | bim_in.ovf;

         x4re_ff  <= x3re_ff;
         x4im_ff  <= x3im_ff;
         vre_ff   <= vre_in;
         vim_ff   <= vim_in;
         tfre_ff  <= tfre_in.val;
         tfim_ff  <= tcim_ff;
         b4re_ff  <= bre_ff;
         b4im_ff  <= bim_ff;
         fl_ff[4] <= fl_ff[3] | v_ovf | tfre_in.ovf;

         epre_ff  <= epre_in.val;
         epim_ff  <= dim.val;
         are_ff   <= are_in.val;
         aim_ff   <= aim_in.val;
         b5re_ff  <= b4re_ff;
         b5im_ff  <= b4im_ff;
         fl_ff[5] <= fl_ff[4] | dre.ovf | dim.ovf | epre_in.ovf
                     | are_in.ovf | aim_in.ovf;

         p_ff[0]  <= rmul(ext(epre_ff), ext(mr_ff[5]), FRAC_BITS);
         p_ff[1]  <= rmul(ext(epim_ff), ext(mi_ff[5]), FRAC_BITS);
         p_ff[2]  <= rmul(ext(are_ff), ext(gp_ff[5]), FRAC_BITS);
         p_ff[3]  <= rmul(ext(b5re_ff), ext(gn_ff[5]), FRAC_BITS);
         p_ff[4]  <= rmul(ext(epre_ff), ext(mi_ff[5]), FRAC_BITS);
         p_ff[5]  <= rmul(ext(epim_ff), ext(mr_ff[5]), FRAC_BITS);
         p_ff[6]  <= rmul(ext(aim_ff), ext(gp_ff[5]), FRAC_BITS);
         p_ff[7]  <= rmul(ext(b5im_ff), ext(gn_ff[5]), FRAC_BITS);
         fl_ff[6] <= fl_ff[5];

         ore_ff   <= ore_in.val;
         oim_ff   <= oim_in.val;
         fl_ff[7] <= fl_ff[6] | ore_in.ovf | oim_in.ovf;
      end
   end

   assign rsp_chan.valid      = v_ff[7];
   assign rsp_chan.mem_re     = ore_ff;
   assign rsp_chan.mem_im     = oim_ff;
   assign rsp_chan.range_flag = fl_ff[7];
endmodule

// ===== hdl/ckup_cmul.sv =====
`timescale 1ns / 1ps
module ckup_cmul #(
   parameter int FRAC_BITS = 16
) (
   input  logic signed [31:0] a_re,
   input  logic signed [31:0] a_im,
   input  logic signed [31:0] b_re,
   input  logic signed [31:0] b_im,
   output logic signed [31:0] r_re,
   output logic signed [31:0] r_im,
   output logic               ovf
);
   import ckup_pkg::*;

   sat_type re_s;
   sat_type im_s;

   always_comb begin
      re_s = sat32(rmul(ext(a_re), ext(b_re), FRAC_BITS)
                 - rmul(ext(a_im), ext(b_im), FRAC_BITS));
      im_s = sat32(rmul(ext(a_re), ext(b_im), FRAC_BITS)
                 + rmul(ext(a_im), ext(b_re), FRAC_BITS));
   end

   assign r_re = re_s.val;
   assign r_im = im_s.val;
   assign ovf  = re_s.ovf | im_s.ovf;
endmodule
